// ----- src/scti_pkg.sv -----
// ----------------------------------------------------------------------------
// scti_pkg: shared types, constants and table functions
// Constants, opcodes, pipeline control type and the first-quadrant sample
// function used at elaboration to build the constant first-quadrant table.
// ----------------------------------------------------------------------------
package scti_pkg;

  // Field widths of the ports.
  localparam int ANGLE_BITS = 24;
  localparam int VALUE_BITS = 16;

  // Parameter defaults and limits.
  localparam int DEF_ANGLE_FRAC_BITS = 8;
  localparam int DEF_SAMPLE_BITS     = 16;
  localparam int SAMPLE_BITS_MAX     = 32;

  // Degree constants.
  localparam int DEG_FULL          = 360;
  localparam int DEG_THREE_QUARTER = 270;
  localparam int DEG_HALF          = 180;
  localparam int DEG_QUARTER       = 90;
  localparam int DEG_BITS          = 9;

  // Sine table geometry: one entry per whole degree, 0 to 360 inclusive.
  localparam int TABLE_ENTRIES   = 361;
  localparam int TABLE_ADDR_BITS = $clog2(TABLE_ENTRIES);
  localparam int QUAD_ENTRIES    = 91;
  localparam int QUAD_IDX_BITS   = $clog2(QUAD_ENTRIES);

  // Fixed-point constants of the table generator (30 fraction bits).
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  // Number of pipeline stages, the output register included.
  localparam int NUM_STAGES = 6;

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } op_e;

  // Per-stage load strobes of the pipeline.
  typedef struct packed {
    logic ld_angle;
    logic ld_recip;
    logic ld_whole;
    logic ld_lookup;
    logic ld_product;
    logic ld_result;
  } pipe_ctrl_t;

  // Sine of d whole degrees (0..90) in Q30, by a thirteen-term Taylor series.
  function automatic longint first_quadrant_q30(input int d);
    longint x;
    longint term;
    longint sum;
    x    = (longint'(d) * PI_Q30) / 180;
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x) / Q30_ONE;
      term = (term * x) / Q30_ONE;
      case (k)
        1:       term = -term / 6;
        2:       term = -term / 20;
        3:       term = -term / 42;
        4:       term = -term / 72;
        5:       term = -term / 110;
        6:       term = -term / 156;
        7:       term = -term / 210;
        8:       term = -term / 272;
        9:       term = -term / 342;
        10:      term = -term / 420;
        11:      term = -term / 506;
        12:      term = -term / 600;
        default: term = 64'sd0;
      endcase
      sum = sum + term;
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    return sum;
  endfunction

  // First-quadrant sample rounded half up and saturated to the sample range.
  function automatic logic [SAMPLE_BITS_MAX-1:0] quadrant_sample(input int d,
                                                                 input int sample_bits);
    longint s;
    longint v;
    longint maxv;
    s    = first_quadrant_q30(d);
    maxv = (64'sd1 <<< (sample_bits - 1)) - 64'sd1;
    v    = (s * (64'sd1 <<< (sample_bits - 1)) + (64'sd1 <<< 29)) >>> 30;
    if (v > maxv) begin
      v = maxv;
    end
    return SAMPLE_BITS_MAX'(v);
  endfunction

endpackage

// ----- src/scti_ram.sv -----
// ----------------------------------------------------------------------------
// scti_ram: generic RAM, one write port and two registered read ports
// Read data are registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module scti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 361,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata0_q;
  logic [WIDTH-1:0] rdata1_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ----- src/scti_fill.sv -----
// ----------------------------------------------------------------------------
// scti_fill: sine table fill sweep after reset
// Writes one table entry per cycle, degrees 0 to 360, built from a constant
// first-quadrant table by symmetry.
// ----------------------------------------------------------------------------
module scti_fill #(
  parameter int SAMPLE_BITS = scti_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  output logic                                 busy_o,
  output logic                                 we_o,
  output logic [scti_pkg::TABLE_ADDR_BITS-1:0] waddr_o,
  output logic [SAMPLE_BITS-1:0]               wdata_o
);

  logic [SAMPLE_BITS-1:0]               quad_rom [scti_pkg::QUAD_ENTRIES];
  logic [scti_pkg::TABLE_ADDR_BITS-1:0] addr_q;
  logic [scti_pkg::TABLE_ADDR_BITS-1:0] addr_d;
  logic                                 busy_q;
  logic                                 busy_d;
  logic [scti_pkg::TABLE_ADDR_BITS-1:0] mirror;
  logic [scti_pkg::QUAD_IDX_BITS-1:0]   quad_idx;
  logic                                 negate;
  logic [SAMPLE_BITS-1:0]               quad_val;

  // Constant first-quadrant samples, worked out at elaboration.
  for (genvar g = 0; g < scti_pkg::QUAD_ENTRIES; g++) begin : g_quad
    assign quad_rom[g] = SAMPLE_BITS'(scti_pkg::quadrant_sample(g, SAMPLE_BITS));
  end

  // Fold the degree into the first quadrant and note the sign.
  always_comb begin
    negate = 1'b0;
    if (addr_q <= scti_pkg::TABLE_ADDR_BITS'(scti_pkg::DEG_QUARTER)) begin
      mirror = addr_q;
    end else if (addr_q <= scti_pkg::TABLE_ADDR_BITS'(scti_pkg::DEG_HALF)) begin
      mirror = scti_pkg::TABLE_ADDR_BITS'(scti_pkg::DEG_HALF) - addr_q;
    end else if (addr_q <= scti_pkg::TABLE_ADDR_BITS'(scti_pkg::DEG_THREE_QUARTER)) begin
      mirror = addr_q - scti_pkg::TABLE_ADDR_BITS'(scti_pkg::DEG_HALF);
      negate = 1'b1;
    end else begin
      mirror = scti_pkg::TABLE_ADDR_BITS'(scti_pkg::DEG_FULL) - addr_q;
      negate = 1'b1;
    end
    quad_idx = mirror[scti_pkg::QUAD_IDX_BITS-1:0];
    quad_val = quad_rom[quad_idx];
  end

  // Sweep counter: stops after the last entry has been written.
  always_comb begin
    addr_d = addr_q;
    busy_d = busy_q;
    if (busy_q) begin
      if (addr_q == scti_pkg::TABLE_ADDR_BITS'(scti_pkg::TABLE_ENTRIES - 1)) begin
        busy_d = 1'b0;
      end else begin
        addr_d = addr_q + scti_pkg::TABLE_ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      busy_q <= 1'b1;
    end else begin
      addr_q <= addr_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o  = busy_q;
  assign we_o    = busy_q;
  assign waddr_o = addr_q;
  assign wdata_o = negate ? (-quad_val) : quad_val;

endmodule

// ----- src/scti_reduce.sv -----
// ----------------------------------------------------------------------------
// scti_reduce: angle reduction into whole degree and fraction
// Three stages: split and offset, reciprocal multiply, remainder with one
// correction step. The whole degree leaves in the range 0 to 359.
// ----------------------------------------------------------------------------
module scti_reduce #(
  parameter int ANGLE_FRAC_BITS = scti_pkg::DEF_ANGLE_FRAC_BITS,
  localparam int FracW = (ANGLE_FRAC_BITS == 0) ? 1 : ANGLE_FRAC_BITS
) (
  input  logic                            clk_i,
  input  scti_pkg::pipe_ctrl_t            ctrl_i,
  input  logic                            opcode_i,
  input  logic [scti_pkg::ANGLE_BITS-1:0] angle_i,
  output logic                            opcode_o,
  output logic [FracW-1:0]                frac_o,
  output logic [scti_pkg::DEG_BITS-1:0]   whole_o
);

  // Whole degrees are offset by a multiple of 360 so that they are never
  // negative; the reciprocal multiply then gives the quotient or one less.
  localparam int WholeW     = scti_pkg::ANGLE_BITS - ANGLE_FRAC_BITS;
  localparam int WrapW      = WholeW + 1;
  localparam int WrapOffset = scti_pkg::DEG_FULL *
                              ((2 ** (WholeW - 1) + scti_pkg::DEG_FULL - 1) /
                               scti_pkg::DEG_FULL);
  localparam int RecipMul   = (2 ** WrapW) / scti_pkg::DEG_FULL;
  localparam int RecipW     = $clog2(RecipMul + 1);
  localparam int ProdW      = WrapW + RecipW;
  localparam int RemW       = WrapW + 1;

  logic signed [scti_pkg::ANGLE_BITS-1:0] angle_s;
  logic signed [scti_pkg::ANGLE_BITS-1:0] whole_s;
  logic [WrapW-1:0]                       wrap1_d;
  logic [FracW-1:0]                       frac1_d;
  logic [WrapW-1:0]                       wrap1_q;
  logic [FracW-1:0]                       frac1_q;
  logic                                   op1_q;
  logic [ProdW-1:0]                       prod2_d;
  logic [ProdW-1:0]                       prod2_q;
  logic [WrapW-1:0]                       wrap2_q;
  logic [FracW-1:0]                       frac2_q;
  logic                                   op2_q;
  logic [RecipW-1:0]                      quot;
  logic [RemW-1:0]                        rem_raw;
  logic [RemW-1:0]                        rem_fix;
  logic [scti_pkg::DEG_BITS-1:0]          whole3_d;
  logic [scti_pkg::DEG_BITS-1:0]          whole3_q;
  logic [FracW-1:0]                       frac3_q;
  logic                                   op3_q;

  // Stage one: arithmetic split into whole degrees and fraction.
  assign angle_s = signed'(angle_i);
  assign whole_s = angle_s >>> ANGLE_FRAC_BITS;
  assign wrap1_d = WrapW'(whole_s) + WrapW'(WrapOffset);

  if (ANGLE_FRAC_BITS == 0) begin : g_no_frac
    assign frac1_d = '0;
  end else begin : g_frac
    assign frac1_d = angle_i[FracW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_angle) begin
      wrap1_q <= wrap1_d;
      frac1_q <= frac1_d;
      op1_q   <= opcode_i;
    end
  end

  // Stage two: multiply by the scaled reciprocal of 360.
  assign prod2_d = ProdW'(wrap1_q) * ProdW'(RecipMul);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_recip) begin
      prod2_q <= prod2_d;
      wrap2_q <= wrap1_q;
      frac2_q <= frac1_q;
      op2_q   <= op1_q;
    end
  end

  // Stage three: remainder, corrected once when the quotient fell short.
  always_comb begin
    quot    = prod2_q[ProdW-1:WrapW];
    rem_raw = RemW'(wrap2_q) - RemW'(quot) * RemW'(scti_pkg::DEG_FULL);
    if (rem_raw >= RemW'(scti_pkg::DEG_FULL)) begin
      rem_fix = rem_raw - RemW'(scti_pkg::DEG_FULL);
    end else begin
      rem_fix = rem_raw;
    end
    whole3_d = rem_fix[scti_pkg::DEG_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_whole) begin
      whole3_q <= whole3_d;
      frac3_q  <= frac2_q;
      op3_q    <= op2_q;
    end
  end

  assign opcode_o = op3_q;
  assign frac_o   = frac3_q;
  assign whole_o  = whole3_q;

endmodule

// ----- src/scti_interp.sv -----
// ----------------------------------------------------------------------------
// scti_interp: linear interpolation between two table samples
// Multiplies the fraction by the sample difference, then adds the floor of
// the scaled product to the first sample and registers the result.
// ----------------------------------------------------------------------------
module scti_interp #(
  parameter int ANGLE_FRAC_BITS = scti_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int SAMPLE_BITS     = scti_pkg::DEF_SAMPLE_BITS,
  localparam int FracW = (ANGLE_FRAC_BITS == 0) ? 1 : ANGLE_FRAC_BITS
) (
  input  logic                            clk_i,
  input  scti_pkg::pipe_ctrl_t            ctrl_i,
  input  logic [FracW-1:0]                frac_i,
  input  logic [SAMPLE_BITS-1:0]          y0_i,
  input  logic [SAMPLE_BITS-1:0]          y1_i,
  output logic [scti_pkg::VALUE_BITS-1:0] value_o
);

  localparam int DiffW = SAMPLE_BITS + 1;
  localparam int ProdW = FracW + DiffW + 1;
  localparam int SumW  = ((SAMPLE_BITS > scti_pkg::VALUE_BITS) ?
                          SAMPLE_BITS : scti_pkg::VALUE_BITS) + 1;

  logic [FracW-1:0]               frac4_q;
  logic signed [SAMPLE_BITS-1:0]  y0_s;
  logic signed [SAMPLE_BITS-1:0]  y1_s;
  logic signed [DiffW-1:0]        diff;
  logic signed [ProdW-1:0]        prod5_d;
  logic signed [ProdW-1:0]        prod5_q;
  logic signed [SAMPLE_BITS-1:0]  y0_5_q;
  logic signed [ProdW-1:0]        step;
  logic signed [SumW-1:0]         sum;
  logic [scti_pkg::VALUE_BITS-1:0] value6_q;

  // The fraction travels alongside the table read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_lookup) begin
      frac4_q <= frac_i;
    end
  end

  // Fraction times difference of the neighbouring samples.
  assign y0_s    = signed'(y0_i);
  assign y1_s    = signed'(y1_i);
  assign diff    = DiffW'(y1_s) - DiffW'(y0_s);
  assign prod5_d = ProdW'(signed'({1'b0, frac4_q})) * ProdW'(diff);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_product) begin
      prod5_q <= prod5_d;
      y0_5_q  <= y0_s;
    end
  end

  // Arithmetic shift rounds towards minus infinity.
  assign step = prod5_q >>> ANGLE_FRAC_BITS;
  assign sum  = SumW'(y0_5_q) + SumW'(step);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_result) begin
      value6_q <= sum[scti_pkg::VALUE_BITS-1:0];
    end
  end

  assign value_o = value6_q;

endmodule

// ----- src/sine_cosine_table_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// sine_cosine_table_interpolator_unit: sine and cosine by table interpolation
// Takes one angle per clock and returns one interpolated sine or cosine per
// clock unless the output is stalled or the table is being filled; each
// result passes reduction, table read, product and output register. The
// rate is set by the sine table RAM, which serves both neighbouring samples
// of an item in one read on its two ports. After reset the table is filled
// by a sweep over its 361 entries, one entry per cycle, while the input is
// stalled. A stall on the output holds the pipeline only as far as it is
// full, so empty stages still take new transfers.
// ----------------------------------------------------------------------------
module sine_cosine_table_interpolator_unit #(
  parameter int ANGLE_FRAC_BITS = scti_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int SAMPLE_BITS     = scti_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [scti_pkg::ANGLE_BITS-1:0] angle_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [scti_pkg::VALUE_BITS-1:0] value_o
);

  localparam int FracW = (ANGLE_FRAC_BITS == 0) ? 1 : ANGLE_FRAC_BITS;
  localparam int NStg  = scti_pkg::NUM_STAGES;
  localparam int AddrW = scti_pkg::TABLE_ADDR_BITS;

  logic                          fill_busy;
  logic                          fill_we;
  logic [AddrW-1:0]              fill_addr;
  logic [SAMPLE_BITS-1:0]        fill_data;
  logic [NStg-1:0]               valid_q;
  logic [NStg-1:0]               valid_d;
  logic [NStg-1:0]               feed;
  logic [NStg:0]                 ready;
  logic [NStg-1:0]               load;
  scti_pkg::pipe_ctrl_t          ctrl;
  logic                          op_s3;
  logic [FracW-1:0]              frac_s3;
  logic [scti_pkg::DEG_BITS-1:0] whole_s3;
  logic [scti_pkg::DEG_BITS-1:0] cos0_sum;
  logic [scti_pkg::DEG_BITS-1:0] cos1_sum;
  logic [AddrW-1:0]              rd_addr0;
  logic [AddrW-1:0]              rd_addr1;
  logic [SAMPLE_BITS-1:0]        y0;
  logic [SAMPLE_BITS-1:0]        y1;

  // Pipeline valid chain: a stage takes a new item when it is empty or
  // its content moves on in the same cycle.
  always_comb begin
    feed        = {valid_q[NStg-2:0], in_valid_i & ~fill_busy};
    ready[NStg] = ~out_stall_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      ready[k] = ~valid_q[k] | ready[k+1];
    end
    load = feed & ready[NStg-1:0];
    for (int k = 0; k < NStg; k++) begin
      valid_d[k] = ready[k] ? feed[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl.ld_angle   = load[0];
  assign ctrl.ld_recip   = load[1];
  assign ctrl.ld_whole   = load[2];
  assign ctrl.ld_lookup  = load[3];
  assign ctrl.ld_product = load[4];
  assign ctrl.ld_result  = load[5];

  assign in_stall_o  = fill_busy | ~ready[0];
  assign out_valid_o = valid_q[NStg-1];

  // Table fill after reset.
  scti_fill #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (fill_busy),
    .we_o   (fill_we),
    .waddr_o(fill_addr),
    .wdata_o(fill_data)
  );

  // Angle reduction.
  scti_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .opcode_i(opcode_i),
    .angle_i (angle_i),
    .opcode_o(op_s3),
    .frac_o  (frac_s3),
    .whole_o (whole_s3)
  );

  // Table addresses: cosine reads a quarter turn further on, wrapping at 360.
  always_comb begin
    cos0_sum = whole_s3 + scti_pkg::DEG_BITS'(scti_pkg::DEG_QUARTER);
    cos1_sum = whole_s3 + scti_pkg::DEG_BITS'(scti_pkg::DEG_QUARTER + 1);
    if (op_s3 == scti_pkg::OP_COSINE) begin
      if (cos0_sum >= scti_pkg::DEG_BITS'(scti_pkg::DEG_FULL)) begin
        rd_addr0 = AddrW'(cos0_sum - scti_pkg::DEG_BITS'(scti_pkg::DEG_FULL));
      end else begin
        rd_addr0 = AddrW'(cos0_sum);
      end
      if (cos1_sum >= scti_pkg::DEG_BITS'(scti_pkg::DEG_FULL)) begin
        rd_addr1 = AddrW'(cos1_sum - scti_pkg::DEG_BITS'(scti_pkg::DEG_FULL));
      end else begin
        rd_addr1 = AddrW'(cos1_sum);
      end
    end else begin
      rd_addr0 = AddrW'(whole_s3);
      rd_addr1 = AddrW'(whole_s3) + AddrW'(1);
    end
  end

  // Sine table.
  scti_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(scti_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_addr),
    .wdata_i (fill_data),
    .re_i    (ctrl.ld_lookup),
    .raddr0_i(rd_addr0),
    .raddr1_i(rd_addr1),
    .rdata0_o(y0),
    .rdata1_o(y1)
  );

  // Interpolation and output register.
  scti_interp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_interp (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .frac_i (frac_s3),
    .y0_i   (y0),
    .y1_i   (y1),
    .value_o(value_o)
  );

  // No item may be in flight while the table is still being filled.
  a_fill_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy |-> (valid_q == '0))
    else $error("item in pipeline during table fill");

  // The fill sweep ends only after the last entry has been written.
  a_fill_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(fill_busy) |-> ($past(fill_addr) == AddrW'(scti_pkg::TABLE_ENTRIES - 1)))
    else $error("table fill ended early");

  // The reduced whole degree is always below a full turn.
  a_whole_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (whole_s3 < scti_pkg::DEG_BITS'(scti_pkg::DEG_FULL)))
    else $error("whole degree out of range");

  // The two table reads are neighbours, wrapping from 359 to 0 for cosine.
  a_addr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ld_lookup |-> ((rd_addr1 == rd_addr0 + AddrW'(1)) ||
                        ((rd_addr0 == AddrW'(scti_pkg::DEG_FULL - 1)) &&
                         (rd_addr1 == '0))))
    else $error("table read addresses not adjacent");

endmodule
